// ===== rtl/core/glos_pkg.sv =====
`timescale 1ns / 1ps
// Package for the grid line-of-sight block: sizes, command codes, state and
// operation enums, controller/datapath struct and corner offset tables. No dependencies.
package glos_pkg;

  localparam int NSLOT    = 64;
  localparam int SLOT_W   = 6;
  localparam int CW       = 16;
  localparam int MAX_STEPS = 4096;
  localparam int SPAN_CAP = (MAX_STEPS - 4) / 4;
  localparam int STW      = $clog2(MAX_STEPS) + 1;
  localparam int RW       = 16;
  localparam int QW       = 20;
  localparam int DW       = 22;
  localparam int DVC_W    = $clog2(DW + 1);
  localparam int ERRW     = 19;
  localparam int PCT_W    = 7;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_LOS    = 2'd1;
  localparam logic [1:0] CMD_OCC    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_LDA, S_LDB, S_SPAN, S_RAY_INIT, S_DIV_LOAD, S_DIV,
    S_RAY_ADV, S_RCELL, S_CELL, S_SCAN, S_HIT, S_MISS, S_OCC_FIN, S_DONE
  } glos_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_TRIV, OP_RD_A, OP_LD_A, OP_LD_B, OP_SPAN,
    OP_RAY_INIT, OP_DIV_LOAD, OP_DIV_STEP, OP_DIV_END, OP_RAY_ADV, OP_RCELL,
    OP_CELL, OP_SCAN, OP_BRES_STEP, OP_SET_HIT, OP_SET_CLEAR, OP_CORNER_HIT,
    OP_CORNER_MISS, OP_SET_OCC
  } glos_op_t;

  typedef struct packed {
    logic trivial;
    logic is_los;
    logic bres_mode;
    logic at_end;
    logic endpoint;
    logic scan_hit;
    logic scan_end;
    logic ray_last;
    logic div_done;
    logic div_last;
    logic corner_last;
  } glos_stat_t;

  // Corner offsets of the target cell in sixth-cell units.
  function automatic logic signed [3:0] glos_off_x(input logic hex, input logic [2:0] c);
    logic signed [3:0] o;
    o = 4'sd0;
    if (hex) begin
      case (c)
        3'd0: o = 4'sd4;
        3'd1: o = 4'sd2;
        3'd2: o = -4'sd2;
        3'd3: o = -4'sd4;
        3'd4: o = -4'sd2;
        3'd5: o = 4'sd2;
        default: o = 4'sd0;
      endcase
    end else begin
      case (c)
        3'd0: o = -4'sd3;
        3'd1: o = 4'sd3;
        3'd2: o = 4'sd3;
        3'd3: o = -4'sd3;
        default: o = 4'sd0;
      endcase
    end
    return o;
  endfunction

  function automatic logic signed [3:0] glos_off_y(input logic hex, input logic [2:0] c);
    logic signed [3:0] o;
    o = 4'sd0;
    if (hex) begin
      case (c)
        3'd0: o = -4'sd2;
        3'd1: o = -4'sd4;
        3'd2: o = -4'sd2;
        3'd3: o = 4'sd2;
        3'd4: o = 4'sd4;
        3'd5: o = 4'sd2;
        default: o = 4'sd0;
      endcase
    end else begin
      case (c)
        3'd0: o = -4'sd3;
        3'd1: o = -4'sd3;
        3'd2: o = 4'sd3;
        3'd3: o = 4'sd3;
        default: o = 4'sd0;
      endcase
    end
    return o;
  endfunction

  // Integer percent of blocked corners, six corners on hex and four on square.
  function automatic logic [PCT_W-1:0] glos_pct(input logic hex, input logic [2:0] hit);
    logic [PCT_W-1:0] p;
    p = '0;
    if (hex) begin
      case (hit)
        3'd0: p = 7'd0;
        3'd1: p = 7'd16;
        3'd2: p = 7'd33;
        3'd3: p = 7'd50;
        3'd4: p = 7'd66;
        3'd5: p = 7'd83;
        3'd6: p = 7'd100;
        default: p = 7'd100;
      endcase
    end else begin
      case (hit)
        3'd0: p = 7'd0;
        3'd1: p = 7'd25;
        3'd2: p = 7'd50;
        3'd3: p = 7'd75;
        default: p = 7'd100;
      endcase
    end
    return p;
  endfunction

endpackage

// ===== rtl/core/glos_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the grid line-of-sight block.
// Depends on glos_pkg; drives one datapath operation per cycle.
module glos_ctrl import glos_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  in_command,
  input  glos_stat_t  stat,
  output glos_op_t    op,
  output logic        busy,
  output logic        done
);

  glos_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && (in_command == CMD_LOS || in_command == CMD_OCC)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK:    state_nxt = stat.trivial ? S_DONE : S_LDA;
      S_LDA:      state_nxt = S_LDB;
      S_LDB:      state_nxt = S_SPAN;
      S_SPAN:     state_nxt = stat.bres_mode ? S_CELL : S_RAY_INIT;
      S_RAY_INIT: state_nxt = S_DIV_LOAD;
      S_DIV_LOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = stat.div_last ? S_RAY_ADV : S_DIV_LOAD;
        end
      end
      S_RAY_ADV:  state_nxt = S_RCELL;
      S_RCELL:    state_nxt = S_CELL;
      S_CELL:     state_nxt = stat.endpoint ? S_MISS : S_SCAN;
      S_SCAN: begin
        if (stat.scan_hit) begin
          state_nxt = S_HIT;
        end else if (stat.scan_end) begin
          state_nxt = S_MISS;
        end
      end
      S_HIT: begin
        if (stat.is_los) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = stat.corner_last ? S_OCC_FIN : S_RAY_INIT;
        end
      end
      S_MISS: begin
        if (stat.bres_mode) begin
          state_nxt = stat.at_end ? S_DONE : S_CELL;
        end else if (!stat.ray_last) begin
          state_nxt = S_RCELL;
        end else if (stat.is_los) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = stat.corner_last ? S_OCC_FIN : S_RAY_INIT;
        end
      end
      S_OCC_FIN:  state_nxt = S_DONE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath operation for the current state.
  always_comb begin
    op = OP_NONE;
    case (state_r)
      S_IDLE:     op = start ? OP_ACCEPT : OP_NONE;
      S_CHECK:    op = stat.trivial ? OP_TRIV : OP_RD_A;
      S_LDA:      op = OP_LD_A;
      S_LDB:      op = OP_LD_B;
      S_SPAN:     op = OP_SPAN;
      S_RAY_INIT: op = OP_RAY_INIT;
      S_DIV_LOAD: op = OP_DIV_LOAD;
      S_DIV:      op = stat.div_done ? OP_DIV_END : OP_DIV_STEP;
      S_RAY_ADV:  op = OP_RAY_ADV;
      S_RCELL:    op = OP_RCELL;
      S_CELL:     op = OP_CELL;
      S_SCAN:     op = OP_SCAN;
      S_HIT:      op = stat.is_los ? OP_SET_HIT : OP_CORNER_HIT;
      S_MISS: begin
        if (stat.bres_mode) begin
          op = stat.at_end ? OP_SET_CLEAR : OP_BRES_STEP;
        end else if (!stat.ray_last) begin
          op = OP_RAY_ADV;
        end else begin
          op = stat.is_los ? OP_SET_CLEAR : OP_CORNER_MISS;
        end
      end
      S_OCC_FIN:  op = OP_SET_OCC;
      S_DONE:     op = OP_NONE;
      default:    op = OP_NONE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule

// ===== rtl/core/glos_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the grid line-of-sight block: slot table, ray accumulators,
// shared serial divider, Bresenham stepper and slot scan. Depends on glos_pkg.
module glos_dp import glos_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  glos_op_t                op,
  input  logic                    topo,
  input  logic [1:0]              in_command,
  input  logic [SLOT_W-1:0]       in_slot,
  input  logic [SLOT_W-1:0]       in_other_slot,
  input  logic signed [CW-1:0]    in_pos_x_in,
  input  logic signed [CW-1:0]    in_pos_y_in,
  input  logic                    in_blocks_in,
  output glos_stat_t              stat,
  output logic                    res_clear,
  output logic                    res_found,
  output logic [SLOT_W-1:0]       res_slot,
  output logic [PCT_W-1:0]        res_pct
);

  function automatic logic signed [DW-1:0] times6(input logic signed [CW-1:0] v);
    logic signed [DW-1:0] w;
    w = DW'(v);
    return (w <<< 2) + (w <<< 1);
  endfunction

  function automatic logic [RW:0] mag(input logic signed [RW:0] v);
    return v[RW] ? (RW+1)'(-v) : (RW+1)'(v);
  endfunction

  // Slot table.
  logic signed [CW-1:0] mem_x_r [NSLOT];
  logic signed [CW-1:0] mem_y_r [NSLOT];
  logic signed [CW-1:0] rd_x_r, rd_y_r;
  logic [NSLOT-1:0]     valid_r, blocks_r;
  logic [SLOT_W-1:0]    rd_addr;

  logic [1:0]           cmd_r;
  logic [SLOT_W-1:0]    slot_a_r, slot_b_r;
  logic signed [CW-1:0] x0_r, y0_r, x1_r, y1_r;

  logic [STW-1:0]       steps_r, s_r;
  logic [RW-1:0]        den_r, dd_r;
  logic signed [DW-1:0] da_r, db_r, dc_r;
  logic signed [QW-1:0] qa_r, qb_r, qc_r, qsa_r, qsb_r, qsc_r;
  logic [RW-1:0]        ra_r, rb_r, rc_r, rsa_r, rsb_r, rsc_r;

  logic [DW-1:0]        div_m_r, div_q_r;
  logic [RW-1:0]        div_rem_r;
  logic [DVC_W-1:0]     div_cnt_r;
  logic                 div_neg_r;
  logic [1:0]           div_sel_r;

  logic signed [QW-1:0] cell_u_r, cell_v_r;
  logic [CW:0]          bdx_r, bdy_r;
  logic signed [ERRW-1:0] err_r;
  logic                 stx_r, sty_r;

  logic [SLOT_W:0]      scan_addr_r;
  logic                 cmp_vld_r;
  logic [SLOT_W-1:0]    cmp_idx_r, found_slot_r;
  logic [2:0]           corner_r, hit_r;

  logic                 res_clear_r, res_found_r;
  logic [SLOT_W-1:0]    res_slot_r;
  logic [PCT_W-1:0]     res_pct_r;

  // Query checks.
  logic va, vb, same, is_los;
  assign va     = valid_r[slot_a_r];
  assign vb     = valid_r[slot_b_r];
  assign same   = (slot_a_r == slot_b_r);
  assign is_los = (cmd_r == CMD_LOS);

  // Span and sample count.
  logic signed [CW:0]   ddx, ddy;
  logic signed [CW+1:0] dsum;
  logic [CW:0]          adx, ady;
  logic [CW+1:0]        asum;
  logic [CW+2:0]        sum3;
  logic [CW+1:0]        span;
  logic [STW-1:0]       steps_calc;
  logic [RW-1:0]        den_calc;

  always_comb begin
    ddx  = (CW+1)'(x1_r) - (CW+1)'(x0_r);
    ddy  = (CW+1)'(y1_r) - (CW+1)'(y0_r);
    dsum = (CW+2)'(ddx) + (CW+2)'(ddy);
    adx  = ddx[CW] ? (CW+1)'(-ddx) : (CW+1)'(ddx);
    ady  = ddy[CW] ? (CW+1)'(-ddy) : (CW+1)'(ddy);
    asum = dsum[CW+1] ? (CW+2)'(-dsum) : (CW+2)'(dsum);
    sum3 = (CW+3)'(adx) + (CW+3)'(ady) + (CW+3)'(asum);
    if (topo) begin
      span = sum3[CW+2:1];
    end else begin
      span = (adx > ady) ? (CW+2)'(adx) : (CW+2)'(ady);
    end
    if (span >= (CW+2)'(SPAN_CAP)) begin
      steps_calc = STW'(MAX_STEPS);
    end else begin
      steps_calc = {span[STW-3:0], 2'b00} + STW'(4);
    end
    den_calc = RW'({steps_calc, 2'b00}) + RW'({steps_calc, 1'b0});
  end

  // Ray start point and deltas.
  logic signed [DW-1:0] tx, ty, da_calc, dc_calc;
  logic signed [3:0]    offx, offy;
  always_comb begin
    offx    = is_los ? 4'sd0 : glos_off_x(topo, corner_r);
    offy    = is_los ? 4'sd0 : glos_off_y(topo, corner_r);
    tx      = times6(x1_r) + DW'(offx);
    ty      = times6(y1_r) + DW'(offy);
    da_calc = tx - times6(x0_r);
    dc_calc = ty - times6(y0_r);
  end

  // Serial divider: one quotient bit per cycle.
  logic signed [DW-1:0] d_sel, two_d;
  logic [RW:0]          rem_sh;
  logic                 rem_ge;
  logic signed [QW-1:0] qpos, qs_calc;
  logic [RW-1:0]        rs_calc;
  always_comb begin
    case (div_sel_r)
      2'd0:    d_sel = da_r;
      2'd1:    d_sel = db_r;
      default: d_sel = dc_r;
    endcase
    two_d  = d_sel <<< 1;
    rem_sh = {div_rem_r, div_m_r[DW-1]};
    rem_ge = (rem_sh >= {1'b0, dd_r});
    qpos   = $signed(div_q_r[QW-1:0]);
    if (div_neg_r && div_rem_r != '0) begin
      qs_calc = -qpos - QW'(1);
      rs_calc = dd_r - div_rem_r;
    end else if (div_neg_r) begin
      qs_calc = -qpos;
      rs_calc = div_rem_r;
    end else begin
      qs_calc = qpos;
      rs_calc = div_rem_r;
    end
  end

  // Accumulator advance: q, r track floor((2p + den) / 2den) for one axis.
  logic [RW:0] suma, sumb, sumc;
  logic        ca, cb, cc;
  always_comb begin
    suma = {1'b0, ra_r} + {1'b0, rsa_r};
    sumb = {1'b0, rb_r} + {1'b0, rsb_r};
    sumc = {1'b0, rc_r} + {1'b0, rsc_r};
    ca   = (suma >= {1'b0, dd_r});
    cb   = (sumb >= {1'b0, dd_r});
    cc   = (sumc >= {1'b0, dd_r});
  end

  // Cube rounding fix-up; rounding error of an axis is |den - r| / 2.
  logic signed [QW+1:0] qsum;
  logic [RW:0]          ea, eb, ec;
  logic                 a_big, b_big, fix;
  logic signed [QW-1:0] cell_u_calc, cell_v_calc;
  always_comb begin
    qsum  = (QW+2)'(qa_r) + (QW+2)'(qb_r) + (QW+2)'(qc_r);
    ea    = mag($signed({1'b0, den_r}) - $signed({1'b0, ra_r}));
    eb    = mag($signed({1'b0, den_r}) - $signed({1'b0, rb_r}));
    ec    = mag($signed({1'b0, den_r}) - $signed({1'b0, rc_r}));
    a_big = (ea > eb) && (ea > ec);
    b_big = !a_big && (eb > ec);
    fix   = topo && (qsum != '0);
    cell_u_calc = (fix && a_big) ? -(qb_r + qc_r) : qa_r;
    cell_v_calc = (fix && !a_big && !b_big) ? -(qa_r + qb_r) : qc_r;
  end

  // Bresenham step.
  logic signed [ERRW:0] e2;
  logic                 c1, c2;
  always_comb begin
    e2 = $signed({err_r, 1'b0});
    c1 = e2 > -$signed((ERRW+1)'(bdy_r));
    c2 = e2 < $signed((ERRW+1)'(bdx_r));
  end

  // Cell tests.
  logic at_v0, at_v1, scan_hit;
  assign at_v0 = (cell_u_r == QW'(x0_r)) && (cell_v_r == QW'(y0_r));
  assign at_v1 = (cell_u_r == QW'(x1_r)) && (cell_v_r == QW'(y1_r));
  assign scan_hit = cmp_vld_r && valid_r[cmp_idx_r] && blocks_r[cmp_idx_r] &&
                    (QW'(rd_x_r) == cell_u_r) && (QW'(rd_y_r) == cell_v_r);

  always_comb begin
    stat.trivial     = !(va && vb) || same;
    stat.is_los      = is_los;
    stat.bres_mode   = is_los && !topo;
    stat.at_end      = at_v1;
    stat.endpoint    = at_v0 || at_v1;
    stat.scan_hit    = scan_hit;
    stat.scan_end    = !cmp_vld_r && scan_addr_r[SLOT_W];
    stat.ray_last    = (s_r == steps_r - STW'(1));
    stat.div_done    = (div_cnt_r == '0);
    stat.div_last    = (div_sel_r == 2'd2);
    stat.corner_last = topo ? (corner_r == 3'd5) : (corner_r == 3'd3);
  end

  always_comb begin
    case (op)
      OP_RD_A: rd_addr = slot_a_r;
      OP_LD_A: rd_addr = slot_b_r;
      default: rd_addr = scan_addr_r[SLOT_W-1:0];
    endcase
  end

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (op == OP_ACCEPT && in_command == CMD_WRITE) begin
      mem_x_r[in_slot] <= in_pos_x_in;
      mem_y_r[in_slot] <= in_pos_y_in;
    end
    rd_x_r <= mem_x_r[rd_addr];
    rd_y_r <= mem_y_r[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      blocks_r    <= '0;
      cmd_r       <= CMD_WRITE;
      cmp_vld_r   <= 1'b0;
      scan_addr_r <= '0;
      div_cnt_r   <= '0;
      div_sel_r   <= '0;
      corner_r    <= '0;
      hit_r       <= '0;
      s_r         <= '0;
    end else begin
      case (op)
        OP_ACCEPT: begin
          cmd_r <= in_command;
          if (in_command == CMD_WRITE) begin
            valid_r[in_slot]  <= 1'b1;
            blocks_r[in_slot] <= in_blocks_in;
          end
        end
        OP_SPAN: begin
          corner_r <= '0;
          hit_r    <= '0;
        end
        OP_RAY_INIT: begin
          s_r       <= '0;
          div_sel_r <= '0;
        end
        OP_DIV_LOAD: div_cnt_r <= DVC_W'(DW);
        OP_DIV_STEP: div_cnt_r <= div_cnt_r - DVC_W'(1);
        OP_DIV_END:  div_sel_r <= div_sel_r + 2'd1;
        OP_RAY_ADV:  s_r <= s_r + STW'(1);
        OP_CELL: begin
          scan_addr_r <= '0;
          cmp_vld_r   <= 1'b0;
        end
        OP_SCAN: begin
          cmp_vld_r <= !scan_addr_r[SLOT_W];
          if (!scan_addr_r[SLOT_W]) begin
            scan_addr_r <= scan_addr_r + (SLOT_W+1)'(1);
          end
        end
        OP_CORNER_HIT: begin
          hit_r    <= hit_r + 3'd1;
          corner_r <= corner_r + 3'd1;
        end
        OP_CORNER_MISS: corner_r <= corner_r + 3'd1;
        default: ;
      endcase
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        slot_a_r <= in_slot;
        slot_b_r <= in_other_slot;
      end
      OP_TRIV: begin
        res_clear_r <= 1'b0;
        res_found_r <= 1'b0;
        res_slot_r  <= '0;
        res_pct_r   <= (!is_los && !(va && vb)) ? PCT_W'(100) : '0;
      end
      OP_LD_A: begin
        x0_r <= rd_x_r;
        y0_r <= rd_y_r;
      end
      OP_LD_B: begin
        x1_r <= rd_x_r;
        y1_r <= rd_y_r;
      end
      OP_SPAN: begin
        steps_r  <= steps_calc;
        den_r    <= den_calc;
        dd_r     <= {den_calc[RW-2:0], 1'b0};
        bdx_r    <= adx;
        bdy_r    <= ady;
        stx_r    <= (x0_r < x1_r);
        sty_r    <= (y0_r < y1_r);
        err_r    <= ERRW'(adx) - ERRW'(ady);
        cell_u_r <= QW'(x0_r);
        cell_v_r <= QW'(y0_r);
      end
      OP_RAY_INIT: begin
        da_r <= da_calc;
        dc_r <= dc_calc;
        db_r <= -(da_calc + dc_calc);
        qa_r <= QW'(x0_r);
        qc_r <= QW'(y0_r);
        qb_r <= -(QW'(x0_r) + QW'(y0_r));
        ra_r <= den_r;
        rb_r <= den_r;
        rc_r <= den_r;
      end
      OP_DIV_LOAD: begin
        div_neg_r <= two_d[DW-1];
        div_m_r   <= two_d[DW-1] ? DW'(-two_d) : DW'(two_d);
        div_rem_r <= '0;
        div_q_r   <= '0;
      end
      OP_DIV_STEP: begin
        div_rem_r <= rem_ge ? RW'(rem_sh - {1'b0, dd_r}) : RW'(rem_sh);
        div_q_r   <= {div_q_r[DW-2:0], rem_ge};
        div_m_r   <= {div_m_r[DW-2:0], 1'b0};
      end
      OP_DIV_END: begin
        case (div_sel_r)
          2'd0: begin
            qsa_r <= qs_calc;
            rsa_r <= rs_calc;
          end
          2'd1: begin
            qsb_r <= qs_calc;
            rsb_r <= rs_calc;
          end
          default: begin
            qsc_r <= qs_calc;
            rsc_r <= rs_calc;
          end
        endcase
      end
      OP_RAY_ADV: begin
        qa_r <= qa_r + qsa_r + QW'(ca);
        qb_r <= qb_r + qsb_r + QW'(cb);
        qc_r <= qc_r + qsc_r + QW'(cc);
        ra_r <= ca ? RW'(suma - {1'b0, dd_r}) : RW'(suma);
        rb_r <= cb ? RW'(sumb - {1'b0, dd_r}) : RW'(sumb);
        rc_r <= cc ? RW'(sumc - {1'b0, dd_r}) : RW'(sumc);
      end
      OP_RCELL: begin
        cell_u_r <= cell_u_calc;
        cell_v_r <= cell_v_calc;
      end
      OP_SCAN: begin
        cmp_idx_r <= scan_addr_r[SLOT_W-1:0];
        if (scan_hit) begin
          found_slot_r <= cmp_idx_r;
        end
      end
      OP_BRES_STEP: begin
        err_r <= err_r - (c1 ? ERRW'(bdy_r) : '0) + (c2 ? ERRW'(bdx_r) : '0);
        if (c1) begin
          cell_u_r <= stx_r ? cell_u_r + QW'(1) : cell_u_r - QW'(1);
        end
        if (c2) begin
          cell_v_r <= sty_r ? cell_v_r + QW'(1) : cell_v_r - QW'(1);
        end
      end
      OP_SET_HIT: begin
        res_clear_r <= 1'b0;
        res_found_r <= 1'b1;
        res_slot_r  <= found_slot_r;
        res_pct_r   <= '0;
      end
      OP_SET_CLEAR: begin
        res_clear_r <= 1'b1;
        res_found_r <= 1'b0;
        res_slot_r  <= '0;
        res_pct_r   <= '0;
      end
      OP_SET_OCC: begin
        res_clear_r <= 1'b0;
        res_found_r <= 1'b0;
        res_slot_r  <= '0;
        res_pct_r   <= glos_pct(topo, hit_r);
      end
      default: ;
    endcase
  end

  assign res_clear = res_clear_r;
  assign res_found = res_found_r;
  assign res_slot  = res_slot_r;
  assign res_pct   = res_pct_r;

endmodule

// ===== rtl/core/grid_line_of_sight_occlusion.sv =====
`timescale 1ns / 1ps
// Top level of the grid line-of-sight and occlusion block.
// Depends on glos_pkg, glos_ctrl and glos_dp.

// The block keeps 64 entity slots and answers line-of-sight and occlusion
// queries between two of them. A beat is taken when start is high and busy is
// low; a write beat fills its slot in that cycle and busy stays low. A query
// raises busy until its result, which appears for exactly one cycle with
// out_strobe high; the receiver cannot stall, so it must take the result then.
// Queries run one at a time and their length depends on the data. Every cell
// on the line is checked against the slot table through its single read port,
// one slot per cycle. A square line-of-sight query walks max(|dx|,|dy|)+1 cells.
// Every sampled ray (the hex line of sight, and each of the four or six corner
// rays of an occlusion query) first runs three serial divisions and then tests
// min(4*span+4, 4096)-1 samples. A query with an unknown or repeated slot goes
// from its check state straight to its result. The topology register is written
// through the cfg_ channel, which is ready whenever the block is idle.
module grid_line_of_sight_occlusion import glos_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_command,
  input  logic [SLOT_W-1:0]      in_slot,
  input  logic [SLOT_W-1:0]      in_other_slot,
  input  logic signed [CW-1:0]   in_pos_x_in,
  input  logic signed [CW-1:0]   in_pos_y_in,
  input  logic                   in_blocks_in,
  output logic                   out_strobe,
  output logic                   out_clear,
  output logic                   out_blocker_found,
  output logic [SLOT_W-1:0]      out_blocker_slot,
  output logic [PCT_W-1:0]       out_occlusion_percent,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_topology
);

  glos_op_t   op;
  glos_stat_t stat;
  logic       topology_r;
  logic       start_ok;

  // Topology register: square grid when clear, hex grid in axial form when set.
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topology_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      topology_r <= cfg_topology;
    end
  end

  // A start seen while busy is not a beat.
  assign start_ok = start && !busy;

  glos_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start_ok),
    .in_command (in_command),
    .stat       (stat),
    .op         (op),
    .busy       (busy),
    .done       (out_strobe)
  );

  glos_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .op            (op),
    .topo          (topology_r),
    .in_command    (in_command),
    .in_slot       (in_slot),
    .in_other_slot (in_other_slot),
    .in_pos_x_in   (in_pos_x_in),
    .in_pos_y_in   (in_pos_y_in),
    .in_blocks_in  (in_blocks_in),
    .stat          (stat),
    .res_clear     (out_clear),
    .res_found     (out_blocker_found),
    .res_slot      (out_blocker_slot),
    .res_pct       (out_occlusion_percent)
  );

  // A result only ends a running query.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

  // One result per query: the block is idle right after a result.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy)
    else $error("block still busy after its result");

  // A clear line never names a blocker.
  a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_clear && out_blocker_found))
    else $error("clear and blocker reported together");

  // Percent stays in range and only occlusion results carry it.
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_occlusion_percent <= PCT_W'(100)) &&
                   !((out_clear || out_blocker_found) && out_occlusion_percent != '0))
    else $error("bad occlusion percent");

endmodule

// ===== dv/grid_line_of_sight_occlusion_test.sv =====
`timescale 1ns / 1ps
// Testbench for grid_line_of_sight_occlusion: a scoreboard class that mirrors the
// slot table and predicts query answers, and tasks that drive beats. Uses glos_pkg.

import glos_pkg::*;

typedef struct {
  bit           clr;
  bit           found;
  bit [5:0]     bslot;
  bit [6:0]     pct;
} los_answer_t;

class los_scoreboard;
  bit          hex_grid;
  longint      cell_x[NSLOT];
  longint      cell_y[NSLOT];
  bit          blocker[NSLOT];
  bit          written[NSLOT];
  los_answer_t answers[$];
  int          errors;
  int          hex_cx[6] = '{4, 2, -2, -4, -2, 2};
  int          hex_cy[6] = '{-2, -4, -2, 2, 4, 2};
  int          sq_cx[4]  = '{-3, 3, 3, -3};
  int          sq_cy[4]  = '{-3, -3, 3, 3};

  function longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function longint floor_quot(longint a, longint b);
    longint q;
    longint r;
    q = a / b;
    r = a % b;
    return r < 0 ? q - 1 : q;
  endfunction

  function longint nearest_quot(longint a, longint b);
    return floor_quot(2 * a + b, 2 * b);
  endfunction

  function longint span(int vi, int ti);
    longint dx;
    longint dy;
    dx = cell_x[vi] - cell_x[ti];
    dy = cell_y[vi] - cell_y[ti];
    if (hex_grid) return (absl(dx) + absl(dy) + absl(dx + dy)) / 2;
    return absl(dx) > absl(dy) ? absl(dx) : absl(dy);
  endfunction

  // Rounds a scaled sample point to a cell; hex uses cube rounding.
  function void round_cell(longint px, longint py, longint den,
                           output longint u, output longint v);
    longint rx, ry, rz, ex, ey, ez;
    if (!hex_grid) begin
      u = nearest_quot(px, den);
      v = nearest_quot(py, den);
      return;
    end
    rx = nearest_quot(px, den);
    ry = nearest_quot(-(px + py), den);
    rz = nearest_quot(py, den);
    if (rx + ry + rz != 0) begin
      ex = absl(rx * den - px);
      ey = absl(ry * den + (px + py));
      ez = absl(rz * den - py);
      if (ex > ey && ex > ez) rx = -ry - rz;
      else if (ey > ez) ry = -rx - rz;
      else rz = -rx - ry;
    end
    u = rx;
    v = rz;
  endfunction

  // Lowest blocking slot on a cell, or -1; the two endpoint cells never block.
  function int lowest_blocker(longint cx, longint cy, int vi, int ti);
    if ((cx == cell_x[vi] && cy == cell_y[vi]) || (cx == cell_x[ti] && cy == cell_y[ti]))
      return -1;
    for (int k = 0; k < NSLOT; k++)
      if (written[k] && blocker[k] && cell_x[k] == cx && cell_y[k] == cy) return k;
    return -1;
  endfunction

  function int sampled_hit(int vi, int ti, longint tx, longint ty);
    longint sx, sy, steps, den, cx, cy;
    int k;
    sx = cell_x[vi] * 6;
    sy = cell_y[vi] * 6;
    steps = 4 * span(vi, ti) + 4;
    if (steps > MAX_STEPS) steps = MAX_STEPS;
    den = 6 * steps;
    for (longint s = 1; s < steps; s++) begin
      round_cell(sx * steps + (tx - sx) * s, sy * steps + (ty - sy) * s, den, cx, cy);
      k = lowest_blocker(cx, cy, vi, ti);
      if (k >= 0) return k;
    end
    return -1;
  endfunction

  function int line_blocker(int vi, int ti);
    longint x1, y1, dx, dy, stx, sty, err, cx, cy, e2;
    int k;
    x1 = cell_x[ti];
    y1 = cell_y[ti];
    if (hex_grid) return sampled_hit(vi, ti, x1 * 6, y1 * 6);
    cx = cell_x[vi];
    cy = cell_y[vi];
    dx = absl(x1 - cx);
    dy = absl(y1 - cy);
    stx = cx < x1 ? 1 : -1;
    sty = cy < y1 ? 1 : -1;
    err = dx - dy;
    forever begin
      k = lowest_blocker(cx, cy, vi, ti);
      if (k >= 0) return k;
      if (cx == x1 && cy == y1) return -1;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        cx += stx;
      end
      if (e2 < dx) begin
        err += dx;
        cy += sty;
      end
    end
  endfunction

  function int hidden_percent(int vi, int ti);
    int hits;
    int corners;
    hits = 0;
    corners = hex_grid ? 6 : 4;
    for (int d = 0; d < corners; d++) begin
      if (hex_grid) begin
        if (sampled_hit(vi, ti, cell_x[ti] * 6 + hex_cx[d], cell_y[ti] * 6 + hex_cy[d]) >= 0)
          hits++;
      end else if (sampled_hit(vi, ti, cell_x[ti] * 6 + sq_cx[d],
                               cell_y[ti] * 6 + sq_cy[d]) >= 0) begin
        hits++;
      end
    end
    return hits * 100 / corners;
  endfunction

  // Updates the table on a write beat, or queues the answer of a query beat.
  function void note_beat(logic [1:0] cmd, int a, int b, logic signed [15:0] x,
                          logic signed [15:0] y, bit blk);
    los_answer_t ans;
    int k;
    ans = '{0, 0, 0, 0};
    case (cmd)
      CMD_WRITE: begin
        cell_x[a] = longint'(x);
        cell_y[a] = longint'(y);
        blocker[a] = blk;
        written[a] = 1;
      end
      CMD_LOS: begin
        if (written[a] && written[b] && a != b) begin
          k = line_blocker(a, b);
          if (k < 0) ans.clr = 1;
          else begin
            ans.found = 1;
            ans.bslot = 6'(k);
          end
        end
        answers.push_back(ans);
      end
      CMD_OCC: begin
        if (!written[a] || !written[b]) ans.pct = 100;
        else if (a != b) ans.pct = 7'(hidden_percent(a, b));
        answers.push_back(ans);
      end
      default: ;
    endcase
  endfunction

  function void check_result(los_answer_t got);
    los_answer_t exp;
    if (answers.size() == 0) begin
      $display("%0t: result with none expected", $time);
      errors++;
      return;
    end
    exp = answers.pop_front();
    if (got.clr !== exp.clr) begin
      $display("%0t: clear expected %0d actual %0d", $time, exp.clr, got.clr);
      errors++;
    end
    if (got.found !== exp.found) begin
      $display("%0t: blocker_found expected %0d actual %0d", $time, exp.found, got.found);
      errors++;
    end
    if (got.bslot !== exp.bslot) begin
      $display("%0t: blocker_slot expected %0d actual %0d", $time, exp.bslot, got.bslot);
      errors++;
    end
    if (got.pct !== exp.pct) begin
      $display("%0t: occlusion_percent expected %0d actual %0d", $time, exp.pct, got.pct);
      errors++;
    end
  endfunction
endclass

module grid_line_of_sight_occlusion_test;

  // Queries on the small random grids are short, so reaching HANG_LIMIT
  // without any beat means the block has hung.
  localparam int HANG_LIMIT = 300000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_command;
  logic [SLOT_W-1:0]   in_slot;
  logic [SLOT_W-1:0]   in_other_slot;
  logic signed [CW-1:0] in_pos_x_in;
  logic signed [CW-1:0] in_pos_y_in;
  logic                in_blocks_in;
  logic                out_strobe;
  logic                out_clear;
  logic                out_blocker_found;
  logic [SLOT_W-1:0]   out_blocker_slot;
  logic [PCT_W-1:0]    out_occlusion_percent;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_topology;

  los_scoreboard sb = new();
  int            quiet_cycles;

  grid_line_of_sight_occlusion i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_slot(in_slot), .in_other_slot(in_other_slot),
    .in_pos_x_in(in_pos_x_in), .in_pos_y_in(in_pos_y_in), .in_blocks_in(in_blocks_in),
    .out_strobe(out_strobe), .out_clear(out_clear), .out_blocker_found(out_blocker_found),
    .out_blocker_slot(out_blocker_slot), .out_occlusion_percent(out_occlusion_percent),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_topology(cfg_topology)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Monitor: everything is sampled at the rising edge, before the block's
  // registers move, so the scoreboard sees exactly what the block saw.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.hex_grid = cfg_topology;
      if (start && !busy)
        sb.note_beat(in_command, in_slot, in_other_slot, in_pos_x_in, in_pos_y_in,
                     in_blocks_in);
      if (out_strobe)
        sb.check_result('{out_clear, out_blocker_found, out_blocker_slot,
                          out_occlusion_percent});
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("grid_line_of_sight_occlusion_test failed");
        $finish;
      end
    end
  end

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // Mostly back-to-back beats, sometimes a short gap and now and then a long one.
  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    idle(r < 95 ? $urandom_range(1, 3) : $urandom_range(20, 60));
  endtask

  // Presents one beat and holds it until the block takes it.
  task automatic send(logic [1:0] cmd, int a, int b, int x, int y, bit blk);
    @(negedge clk);
    start = 1'b1;
    in_command = cmd;
    in_slot = SLOT_W'(a);
    in_other_slot = SLOT_W'(b);
    in_pos_x_in = CW'(x);
    in_pos_y_in = CW'(y);
    in_blocks_in = blk;
    do @(posedge clk); while (busy);
  endtask

  task automatic put_slot(int a, int x, int y, bit blk);
    send(CMD_WRITE, a, $urandom_range(0, 63), x, y, blk);
  endtask

  task automatic ask(logic [1:0] cmd, int a, int b);
    send(cmd, a, b, $urandom, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Waits for all answers to drain, then lets the block settle before the
  // topology changes.
  task automatic drain();
    idle(1);
    while (sb.answers.size() != 0) @(posedge clk);
    idle(50);
  endtask

  task automatic set_topology(bit hex);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_topology = hex;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Corner cases: unwritten slots, same slot, endpoint cells holding
  // blockers, blockers on the line, unused command and the coordinate extremes.
  task automatic run_directed();
    ask(CMD_LOS, 40, 41);
    ask(CMD_OCC, 40, 41);
    put_slot(0, 0, 0, 0);
    put_slot(1, 4, 2, 0);
    put_slot(2, 2, 1, 1);
    put_slot(3, 1, 0, 1);
    put_slot(4, 0, 0, 1);
    put_slot(5, 4, 2, 1);
    ask(CMD_LOS, 0, 1);
    ask(CMD_LOS, 1, 0);
    ask(CMD_LOS, 0, 0);
    ask(CMD_OCC, 0, 0);
    ask(CMD_OCC, 0, 1);
    ask(CMD_OCC, 1, 40);
    ask(CMD_LOS, 0, 40);
    send(CMD_UNUSED, 0, 1, 0, 0, 0);
    put_slot(60, 32767, 32767, 1);
    put_slot(61, 32766, 32767, 0);
    put_slot(62, -32768, -32768, 1);
    put_slot(63, -32766, -32767, 0);
    ask(CMD_LOS, 62, 63);
    ask(CMD_OCC, 63, 62);
    ask(CMD_LOS, 61, 60);
    ask(CMD_OCC, 60, 61);
    for (int k = 60; k < 64; k++) put_slot(k, k - 62, 1, k[0]);
  endtask

  // Random phase on a small grid so lines stay short; slots 56 to 59 are never
  // written, so queries also see unknown slots.
  task automatic run_random(int beats);
    int r;
    int a;
    for (int n = 0; n < beats; ) begin
      random_gap();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        a = $urandom_range(0, 59);
        if (a >= 56) a += 4;
        put_slot(a, $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                 $urandom_range(0, 99) < 40);
        n++;
      end else if (r < 95) begin
        ask(r < 75 ? CMD_LOS : CMD_OCC, $urandom_range(0, 63),
            $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 20));
        n++;
      end else begin
        send(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), $urandom, $urandom, 0);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_WRITE;
    in_slot = '0;
    in_other_slot = '0;
    in_pos_x_in = '0;
    in_pos_y_in = '0;
    in_blocks_in = 1'b0;
    cfg_valid = 1'b0;
    cfg_topology = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    set_topology(1'b0);
    run_directed();
    set_topology(1'b1);
    run_directed();
    run_random(250);
    set_topology(1'b0);
    run_random(250);
    set_topology(1'b1);
    run_random(250);
    set_topology(1'b0);
    run_random(250);

    idle(1);
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("grid_line_of_sight_occlusion_test passed");
    end else begin
      $display("grid_line_of_sight_occlusion_test failed");
    end
    $finish;
  end

endmodule
